// ===== design/sspn_pkg.sv =====
// Shared types and constants for the spectrum smoothing peak normalizer.
// Used by the controller, datapath and top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sspn_pkg;

   typedef struct packed {
      logic        kind;
      logic [7:0]  bin;
      logic [31:0] magnitude;
      logic        frame_last;
      logic [1:0]  view;
   } req_type;

   typedef struct packed {
      logic [31:0] value;
      logic        in_range;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FETCH, ST_DECIDE, ST_MUL, ST_SUM, ST_PEAK, ST_DECAY, ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic fetch;
      logic mul;
      logic sum;
      logic direct;
      logic div_read;
      logic peak;
      logic decay;
      logic div_finish;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic item_valid;
      logic kind;
      logic last_en;
      logic view_direct;
      logic peak_jump;
      logic div_done;
      logic rsp_free;
   } status_type;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic [1:0] VIEW_RAW_PEAK = 2'd0;
   localparam logic [1:0] VIEW_SMO_PEAK = 2'd1;
   localparam logic [1:0] VIEW_RAW      = 2'd2;
   localparam logic [1:0] VIEW_SMOOTH   = 2'd3;

   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_FACTOR = 1'b1;

   localparam logic [31:0] PEAK_RESET   = 32'd6554;
   localparam logic [31:0] PEAK_FLOOR   = 32'd7;
   localparam logic [31:0] ONE_Q16      = 32'd65536;
   localparam logic [15:0] FACTOR_RESET = 16'd52429;
   // decay step is floor((gap + 49) / 100), taken as ((gap + 49) >> 2) * recip >> 35
   localparam logic [32:0] DECAY_BIAS   = 33'd49;
   localparam logic [31:0] DECAY_RECIP  = 32'h51EB_851F;

endpackage
`default_nettype wire

// ===== design/sspn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sspn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== design/sspn_div.sv =====
// Restoring divider, one quotient bit per cycle, 48-bit dividend, 32-bit divisor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sspn_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [47:0] dividend,
   input  wire logic [31:0] divisor,
   output logic      [47:0] quotient,
   output logic             done
);
   localparam logic [5:0] LAST_STEP = 6'd47;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [32:0] shifted;
   logic [32:0] diff;
   logic        ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[47]};
      diff    = shifted - {1'b0, div_ff};
      ge      = shifted >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[31:0] : shifted[31:0];
         quo_in = {quo_ff[46:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule
`default_nettype wire

// ===== design/sspn_datapath.sv =====
// Datapath: bin stores, smoothing multipliers, peak tracker, divider and result register.
// Depends on sspn_pkg, sspn_ram and sspn_div.
`timescale 1ns / 1ps
`default_nettype none
module sspn_datapath #(
   parameter int NUM_BINS = 128
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sspn_pkg::req_type   req_data,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output sspn_pkg::rsp_type        rsp_data,
   input  wire logic                csr_write,
   input  wire logic                csr_index,
   input  wire logic [15:0]         csr_wdata,
   input  wire sspn_pkg::cmd_type   cmd,
   output sspn_pkg::status_type     status
);
   import sspn_pkg::*;

   localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam logic [8:0] BIN_LIMIT = 9'(NUM_BINS);

   req_type     req_ff, req_in;
   logic        enable_ff, enable_in;
   logic [15:0] factor_ff, factor_in;
   logic [31:0] peak_ff, peak_in;
   logic [31:0] fmax_ff, fmax_in;
   logic [NUM_BINS-1:0] vld_ff, vld_in;
   logic [47:0] prod_old_ff, prod_old_in;
   logic [48:0] prod_new_ff, prod_new_in;
   logic [62:0] decay_prod_ff, decay_prod_in;
   logic [31:0] value_ff, value_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0] addr;
   logic [31:0]   raw_q, smo_q, raw_op, smo_op;
   logic          item_valid;
   logic [49:0]   sum;
   logic [31:0]   smoothed;
   logic [31:0]   peak_base;
   logic          jump;
   logic [31:0]   decay_gap;
   logic [32:0]   decay_biased;
   logic [31:0]   decay_step;
   logic [31:0]   decayed;
   logic          div_start;
   logic [47:0]   div_dividend;
   logic [31:0]   div_divisor;
   logic [47:0]   quotient;
   logic          div_done;
   logic [31:0]   sel_op;
   logic [16:0]   new_weight;

   assign addr = req_ff.bin[AW-1:0];

   sspn_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_raw (
      .clock(clock), .wr_en(cmd.sum), .wr_addr(addr), .wr_data(req_ff.magnitude),
      .rd_en(cmd.fetch), .rd_addr(addr), .rd_data(raw_q)
   );

   sspn_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_smo (
      .clock(clock), .wr_en(cmd.sum), .wr_addr(addr), .wr_data(smoothed),
      .rd_en(cmd.fetch), .rd_addr(addr), .rd_data(smo_q)
   );

   sspn_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .quotient(quotient), .done(div_done)
   );

   always_comb begin
      item_valid = enable_ff && ({1'b0, req_ff.bin} < BIN_LIMIT);
      // a bin never written reads as zero
      raw_op     = vld_ff[addr] ? raw_q : '0;
      smo_op     = vld_ff[addr] ? smo_q : '0;
      sel_op     = (req_ff.view == VIEW_RAW_PEAK) ? raw_op : smo_op;
      new_weight = 17'h10000 - {1'b0, factor_ff};
      sum        = {2'b00, prod_old_ff} + {1'b0, prod_new_ff} + 50'd32768;
      smoothed   = sum[47:16];
      peak_base  = (peak_ff == '0) ? PEAK_RESET : peak_ff;
      jump       = fmax_ff > peak_base;

      // no borrow: the gap is only used when the maximum stays at or below the peak
      decay_gap    = peak_base - fmax_ff;
      decay_biased = {1'b0, decay_gap} + DECAY_BIAS;
      decay_step   = {4'h0, decay_prod_ff[62:35]};
      decayed      = peak_base - decay_step;

      div_start    = cmd.div_read;
      div_dividend = {sel_op, 16'h0000};
      div_divisor  = (peak_ff == '0) ? 32'd1 : peak_ff;

      req_in        = req_ff;
      enable_in     = enable_ff;
      factor_in     = factor_ff;
      peak_in       = peak_ff;
      fmax_in       = fmax_ff;
      vld_in        = vld_ff;
      prod_old_in   = prod_old_ff;
      prod_new_in   = prod_new_ff;
      decay_prod_in = decay_prod_ff;
      value_in      = value_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_ENABLE: enable_in = csr_wdata[0];
            CSR_FACTOR: factor_in = csr_wdata;
            default:    enable_in = enable_ff;
         endcase
      end

      if (cmd.capture) begin
         req_in   = req_data;
         value_in = '0;
      end
      if (cmd.mul) begin
         prod_old_in = smo_op * factor_ff;
         prod_new_in = req_ff.magnitude * new_weight;
      end
      if (cmd.sum) begin
         vld_in[addr] = 1'b1;
         value_in     = smoothed;
         if (smoothed > fmax_ff) begin
            fmax_in = smoothed;
         end
      end
      if (cmd.direct) begin
         value_in = req_ff.view[0] ? smo_op : raw_op;
      end
      if (cmd.peak) begin
         fmax_in       = '0;
         decay_prod_in = decay_biased[32:2] * DECAY_RECIP;
         if (jump) begin
            peak_in = (fmax_ff < PEAK_FLOOR) ? PEAK_FLOOR : fmax_ff;
         end
      end
      if (cmd.decay) begin
         peak_in = (decayed < PEAK_FLOOR) ? PEAK_FLOOR : decayed;
      end
      if (cmd.div_finish) begin
         if (req_ff.view == VIEW_RAW_PEAK) begin
            value_in = (quotient[47:32] != '0) ? 32'hFFFF_FFFF : quotient[31:0];
         end else begin
            value_in = (quotient > {16'h0000, ONE_Q16}) ? ONE_Q16 : quotient[31:0];
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in    = 1'b1;
         rsp_in.value    = value_ff;
         rsp_in.in_range = item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         factor_ff    <= FACTOR_RESET;
         peak_ff      <= PEAK_RESET;
         fmax_ff      <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         factor_ff    <= factor_in;
         peak_ff      <= peak_in;
         fmax_ff      <= fmax_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      prod_old_ff   <= prod_old_in;
      prod_new_ff   <= prod_new_in;
      decay_prod_ff <= decay_prod_in;
      value_ff      <= value_in;
      rsp_ff        <= rsp_in;
   end

   always_comb begin
      status.item_valid  = item_valid;
      status.kind        = req_ff.kind;
      status.last_en     = enable_ff && req_ff.frame_last;
      status.view_direct = req_ff.view[1];
      status.peak_jump   = jump;
      status.div_done    = div_done;
      status.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

// ===== design/sspn_ctrl.sv =====
// Controller state machine sequencing one item through the datapath.
// Depends on sspn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sspn_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire sspn_pkg::status_type status,
   output sspn_pkg::cmd_type         cmd
);
   import sspn_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!status.item_valid) begin
               // a write outside the bins still closes the frame
               if (status.kind == KIND_WRITE && status.last_en) begin
                  state_in = ST_PEAK;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (status.kind == KIND_WRITE) begin
               state_in = ST_MUL;
            end else if (status.view_direct) begin
               cmd.direct = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.div_read = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = status.last_en ? ST_PEAK : ST_FINISH;
         end
         ST_PEAK: begin
            cmd.peak = 1'b1;
            state_in = status.peak_jump ? ST_FINISH : ST_DECAY;
         end
         ST_DECAY: begin
            cmd.decay = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               cmd.div_finish = 1'b1;
               state_in       = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== design/spectrum_smoothing_peak_normalizer.sv =====
// Top level of the spectrum smoothing peak normalizer.
// Depends on sspn_pkg, sspn_ctrl and sspn_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Takes one item at a time. A write stores the magnitude, blends it into the
// smoothed bin value and returns that value; when it closes a frame it also
// passes through the peak step, and through a decay step as well when there is
// no jump to a new maximum (a reciprocal multiply for the divide by 100). Reads
// of the raw or smoothed view read the bin stores directly; the views over the
// peak go through a 48-step restoring divider. The next item is accepted in the
// cycle after the result is loaded into the output register, even while that
// result is still stalled. Bins never written read as zero.
module spectrum_smoothing_peak_normalizer #(
   parameter int NUM_BINS = 128
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sspn_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sspn_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic              csr_index,
   input  wire logic [15:0]       csr_wdata
);
   import sspn_pkg::*;

   cmd_type    cmd;
   status_type status;

   sspn_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .status(status), .cmd(cmd)
   );

   sspn_datapath #(.NUM_BINS(NUM_BINS)) u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_write(csr_write),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .cmd(cmd), .status(status)
   );
endmodule
`default_nettype wire
